// ===== rtl/core/wtv_pkg.sv =====
`default_nettype none

package wtv_pkg;

    localparam int DIV_W  = 28;
    localparam int DVS_W  = 17;
    localparam int VOL_W  = 12;
    localparam int SMP_W  = 16;
    localparam int OUT_W  = 28;
    localparam int PROD_W = 30;
    localparam int IDX_W  = 10;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_IW-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_DECAY   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_SUSTAIN = 3'd2;
    localparam logic [CFG_IW-1:0] REG_RELEASE = 3'd3;
    localparam logic [CFG_IW-1:0] REG_PERIOD  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_PEAK    = 3'd5;

    localparam logic [10:0]      PERIOD_RST = 11'd100;
    localparam logic [VOL_W-1:0] PEAK_RST   = 12'd2500;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_LOAD    = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENV,
        ST_MUL,
        ST_EDIV_GO,
        ST_EDIV,
        ST_POS,
        ST_PDIV,
        ST_READ,
        ST_SMUL,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        ENV_ATTACK,
        ENV_RISE,
        ENV_FALL,
        ENV_RELEASE
    } env_mode_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/wavetable_voice_adsr.sv =====
// Wavetable voice with ADSR envelope. Each word on the s_ side is a tick, a
// release or a table load (kind in s_tuser). Loads and releases give no
// result. A tick gives one word on the m_ side: the stored sample at the next
// read position times the envelope volume, or zero with the finished flag once
// the release has run down. A tick runs the envelope division during attack,
// decay and release ramps, and a position division when the read position lies
// beyond a shortened period; both use the shared restoring divider (one bit a
// cycle over 28 bits), and a stalled output holds the tick back. The input is
// not ready while a tick is in progress; a finished result waits in the output
// register while the next word is taken. Table entries never loaded read back
// as undefined.
`default_nettype none

module wavetable_voice_adsr
    import wtv_pkg::*;
#(
    parameter int MAX_PERIOD     = 1024,
    parameter int TICKS_PER_STEP = 50
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // table_index[9:0], table_value[25:10]
    input  wire logic [1:0]             s_tuser,   // action[1:0]

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // sample_out[27:0]
    output logic [0:0]                  m_tuser,   // finished[0]

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IW-1:0]      cfg_index,
    input  wire logic [CFG_DW-1:0]      cfg_data
);

    localparam int AW  = $clog2(MAX_PERIOD);
    localparam int PEW = $clog2(MAX_PERIOD + 1);
    localparam int RW  = $clog2(TICKS_PER_STEP + 1);

    state_t state_reg, state_next;

    logic [15:0]      attack_len_reg, decay_len_reg, release_len_reg;
    logic [VOL_W-1:0] sustain_level_reg, peak_level_reg;
    logic [10:0]      period_len_reg;

    logic [31:0]      tick_cnt_reg, tick_cnt_next;
    logic [31:0]      step_reg, step_next;
    logic [RW-1:0]    sub_reg, sub_next;
    logic [VOL_W-1:0] volume_reg, volume_next;
    logic [VOL_W-1:0] rstart_reg, rstart_next;
    logic             releasing_reg, releasing_next;
    logic [AW-1:0]    pos_reg, pos_next;

    env_mode_t           mode_reg, mode_next;
    logic [VOL_W-1:0]    mul_a_reg, mul_a_next;
    logic signed [16:0]  mul_b_reg, mul_b_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                fin_reg, fin_next;

    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_sample_reg, out_sample_next;
    logic             out_fin_reg, out_fin_next;

    logic [SMP_W-1:0] wave_mem [MAX_PERIOD];
    logic [SMP_W-1:0] rd_data_reg;

    logic             s_accept;
    logic [1:0]       in_action;
    logic [IDX_W-1:0] in_index;
    logic [SMP_W-1:0] in_value;
    logic             mem_we;

    logic [31:0]      decay_off;
    logic             env_fin, env_clamp, env_attack, env_decay;
    logic [PEW-1:0]   p_eff, pos_inc;
    logic             pos_direct, pos_wrap;
    logic             out_free;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    div_rsp_t         div_rsp;

    logic [VOL_W-1:0]         mul_x;
    logic signed [16:0]       mul_y;
    logic signed [PROD_W-1:0] prod;
    logic [VOL_W-1:0]         quo12;

    assign in_action = s_tuser;
    assign in_index  = s_tdata[IDX_W-1:0];
    assign in_value  = s_tdata[IDX_W+SMP_W-1:IDX_W];
    assign s_accept  = s_tvalid && s_tready;
    assign mem_we    = s_accept && (in_action == ACT_LOAD)
                       && (32'(in_index) < 32'(MAX_PERIOD));
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_len_reg    <= '0;
            decay_len_reg     <= '0;
            sustain_level_reg <= '0;
            release_len_reg   <= '0;
            period_len_reg    <= PERIOD_RST;
            peak_level_reg    <= PEAK_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ATTACK:  attack_len_reg    <= cfg_data;
                REG_DECAY:   decay_len_reg     <= cfg_data;
                REG_SUSTAIN: sustain_level_reg <= cfg_data[VOL_W-1:0];
                REG_RELEASE: release_len_reg   <= cfg_data;
                REG_PERIOD:  period_len_reg    <= cfg_data[10:0];
                REG_PEAK:    peak_level_reg    <= cfg_data[VOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            wave_mem[AW'(in_index)] <= in_value;
        end
        rd_data_reg <= wave_mem[pos_reg];
    end

    wtv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .rsp      (div_rsp)
    );

    // shared multiplier: envelope ramp or output sample
    assign mul_x = (state_reg == ST_SMUL) ? volume_reg : mul_a_reg;
    assign mul_y = (state_reg == ST_SMUL) ? {rd_data_reg[SMP_W-1], rd_data_reg} : mul_b_reg;
    assign prod  = $signed({1'b0, mul_x}) * mul_y;
    assign quo12 = div_rsp.quotient[VOL_W-1:0];

    always_comb begin
        decay_off  = step_reg - {16'b0, attack_len_reg};
        env_fin    = releasing_reg && (volume_reg == '0);
        env_clamp  = releasing_reg && (step_reg >= 32'(release_len_reg) + 32'd1);
        env_attack = step_reg < {16'b0, attack_len_reg};
        env_decay  = decay_off < {16'b0, decay_len_reg};
        if (period_len_reg == '0) begin
            p_eff = PEW'(1);
        end else if (32'(period_len_reg) > 32'(MAX_PERIOD)) begin
            p_eff = PEW'(MAX_PERIOD);
        end else begin
            p_eff = PEW'(period_len_reg);
        end
        pos_inc    = PEW'(pos_reg) + PEW'(1);
        pos_direct = pos_inc < p_eff;
        pos_wrap   = pos_inc == p_eff;
        out_free   = !out_valid_reg || m_tready;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && in_action == ACT_TICK) state_next = ST_ENV;
            end
            ST_ENV: begin
                priority if (env_fin) state_next = ST_OUT;
                else if (env_clamp) state_next = ST_POS;
                else if (releasing_reg || env_attack || env_decay) state_next = ST_MUL;
                else state_next = ST_POS;
            end
            ST_MUL:     state_next = ST_EDIV_GO;
            ST_EDIV_GO: state_next = ST_EDIV;
            ST_EDIV: begin
                if (div_rsp.done) state_next = ST_POS;
            end
            ST_POS: begin
                if (pos_direct || pos_wrap) state_next = ST_READ;
                else state_next = ST_PDIV;
            end
            ST_PDIV: begin
                if (div_rsp.done) state_next = ST_READ;
            end
            ST_READ: state_next = ST_SMUL;
            ST_SMUL: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake and divider control
    always_comb begin
        s_tready     = 1'b0;
        div_start    = 1'b0;
        div_dividend = prod_reg[DIV_W-1:0];
        div_divisor  = dvs_reg;
        unique case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_EDIV_GO: div_start = 1'b1;
            ST_POS: begin
                div_start    = !(pos_direct || pos_wrap);
                div_dividend = DIV_W'(pos_inc);
                div_divisor  = DVS_W'(p_eff);
            end
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        tick_cnt_next   = tick_cnt_reg;
        step_next       = step_reg;
        sub_next        = sub_reg;
        volume_next     = volume_reg;
        rstart_next     = rstart_reg;
        releasing_next  = releasing_reg;
        pos_next        = pos_reg;
        mode_next       = mode_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        dvs_next        = dvs_reg;
        prod_next       = prod_reg;
        fin_next        = fin_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_sample_next = out_sample_reg;
        out_fin_next    = out_fin_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && in_action == ACT_TICK && tick_cnt_reg != '1) begin
                    tick_cnt_next = tick_cnt_reg + 32'd1;
                    if (sub_reg == RW'(TICKS_PER_STEP - 1)) begin
                        sub_next  = '0;
                        step_next = step_reg + 32'd1;
                    end else begin
                        sub_next = sub_reg + RW'(1);
                    end
                end else if (s_accept && in_action == ACT_RELEASE) begin
                    releasing_next = 1'b1;
                    tick_cnt_next  = '0;
                    step_next      = '0;
                    sub_next       = '0;
                    rstart_next    = volume_reg;
                end
            end
            ST_ENV: begin
                fin_next = env_fin;
                priority if (env_fin) begin
                    fin_next = 1'b1;
                end else if (env_clamp) begin
                    volume_next = '0;
                end else if (releasing_reg) begin
                    mode_next  = ENV_RELEASE;
                    mul_a_next = rstart_reg;
                    mul_b_next = {1'b0, step_reg[15:0]};
                    dvs_next   = DVS_W'(release_len_reg) + DVS_W'(1);
                end else if (env_attack) begin
                    mode_next  = ENV_ATTACK;
                    mul_a_next = peak_level_reg;
                    mul_b_next = {1'b0, step_reg[15:0]};
                    dvs_next   = {1'b0, attack_len_reg};
                end else if (env_decay) begin
                    if (sustain_level_reg >= peak_level_reg) begin
                        mode_next  = ENV_RISE;
                        mul_a_next = sustain_level_reg - peak_level_reg;
                    end else begin
                        mode_next  = ENV_FALL;
                        mul_a_next = peak_level_reg - sustain_level_reg;
                    end
                    mul_b_next = {1'b0, decay_off[15:0]};
                    dvs_next   = {1'b0, decay_len_reg};
                end else begin
                    volume_next = sustain_level_reg;
                end
            end
            ST_MUL:  prod_next = prod;
            ST_EDIV: begin
                if (div_rsp.done) begin
                    unique case (mode_reg)
                        ENV_ATTACK:  volume_next = quo12;
                        ENV_RISE:    volume_next = peak_level_reg + quo12;
                        ENV_FALL:    volume_next = peak_level_reg - quo12;
                        ENV_RELEASE: volume_next = rstart_reg - quo12;
                        default:     volume_next = quo12;
                    endcase
                end
            end
            ST_POS: begin
                if (pos_direct) begin
                    pos_next = AW'(pos_inc);
                end else if (pos_wrap) begin
                    pos_next = '0;
                end
            end
            ST_PDIV: begin
                if (div_rsp.done) pos_next = AW'(div_rsp.remainder);
            end
            ST_SMUL: prod_next = prod;
            ST_OUT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_sample_next = fin_reg ? '0 : prod_reg[OUT_W-1:0];
                    out_fin_next    = fin_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tick_cnt_reg  <= '0;
            step_reg      <= '0;
            sub_reg       <= '0;
            volume_reg    <= '0;
            rstart_reg    <= '0;
            releasing_reg <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tick_cnt_reg  <= tick_cnt_next;
            step_reg      <= step_next;
            sub_reg       <= sub_next;
            volume_reg    <= volume_next;
            rstart_reg    <= rstart_next;
            releasing_reg <= releasing_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
        mode_reg       <= mode_next;
        mul_a_reg      <= mul_a_next;
        mul_b_reg      <= mul_b_next;
        dvs_reg        <= dvs_next;
        prod_reg       <= prod_next;
        fin_reg        <= fin_next;
        out_sample_reg <= out_sample_next;
        out_fin_reg    <= out_fin_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_sample_reg};
    assign m_tuser  = out_fin_reg;

`ifndef SYNTHESIS
    a_fin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("finished word carries a non-zero sample");

    a_release_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_action == ACT_RELEASE) |=> (tick_cnt_reg == '0 && releasing_reg))
        else $error("release did not restart the tick count");

    a_div_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_EDIV || state_reg == ST_PDIV))
        else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/wtv_div.sv =====
`default_nettype none

module wtv_div
    import wtv_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output div_rsp_t              rsp
);

    localparam int CW = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;

    // restoring, one quotient bit a cycle
    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(DIV_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> rem_reg < dvs_reg)
        else $error("divider remainder not below divisor");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a pass");
`endif

endmodule

`default_nettype wire
